@@ rtl/gspe_pkg.sv @@
`timescale 1ns / 1ps
package gspe_pkg;
   localparam int GRID_ROWS_DEF  = 16;
   localparam int GRID_COLS_DEF  = 16;
   localparam int SHAPE_SIDE_DEF = 8;
   localparam int ID_BITS_DEF    = 8;

   localparam int CELL_W  = 9;
   localparam int MASK_W  = 64;
   localparam int SIZE_W  = 5;
   localparam int CNT_W   = 9;
   localparam int SCNT_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] OP_CHECK  = 2'd0;
   localparam logic [1:0] OP_STAMP  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_WRITE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture the request beat
      logic shape_step; // visit one shape cell
      logic sweep_step; // visit one grid cell (remove and count)
      logic sweep_clr;  // clear sweep position and counters
      logic write_cell; // perform the single cell write
      logic mod_start;  // begin the remainder
      logic mod_step;   // one restoring step
      logic emit;       // present the result beat
   } gspe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic shape_last;
      logic sweep_last;
      logic mod_last;
      logic [1:0] op;
   } gspe_sts_type;
endpackage

@@ rtl/grid_shape_placement_engine.sv @@
`timescale 1ns / 1ps
// Grid shape placement engine.
// Request: raise start with the req_ fields while busy is low; the beat is
// taken on that edge and busy rises on the next cycle.
// Each request runs check, stamp, remove or single cell write on the
// occupancy grid, then counts the empty cells of the sheet in use.
// Result: rsp_valid strobes for one cycle with the rsp_ fields; the receiver
// cannot stall, so the beat must be taken then.
// The time from request to result is set by the one-cell-a-cycle shape walk over
// clamped rows times clamped columns (each counted as at least one), the grid
// sweep through the single registered read port and the nine-step remainder.
// One request at a time; the next can be taken in the cycle after the result.
// csr_write/csr_index/csr_data set rows and columns in use; write while idle.
// Reset: synchronous, active high; the grid reads empty, sizes return to 16.
module grid_shape_placement_engine
   import gspe_pkg::*;
#(
   parameter int GRID_ROWS  = GRID_ROWS_DEF,
   parameter int GRID_COLS  = GRID_COLS_DEF,
   parameter int SHAPE_SIDE = SHAPE_SIDE_DEF,
   parameter int ID_BITS    = ID_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_op,
   input  logic [3:0]               req_row,
   input  logic [3:0]               req_col,
   input  logic [MASK_W-1:0]        req_shape_mask,
   input  logic [3:0]               req_shape_rows,
   input  logic [3:0]               req_shape_cols,
   input  logic [7:0]               req_piece_id,
   input  logic signed [CELL_W-1:0] req_cell_value,
   output logic                     rsp_valid,
   output logic                     rsp_fits,
   output logic [CNT_W-1:0]         rsp_empty_cells,
   output logic [SCNT_W-1:0]        rsp_shape_cells,
   output logic                     rsp_divisible,
   output logic                     rsp_full_res,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SIZE_W-1:0]        csr_data
);
   gspe_cmd_type cmd;
   gspe_sts_type sts;
   logic start_ok;
   assign start_ok = start && !busy;

   gspe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start_ok), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .sts(sts)
   );

   gspe_datapath #(
      .GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS),
      .SHAPE_SIDE(SHAPE_SIDE), .ID_BITS(ID_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_op(req_op), .req_row(req_row), .req_col(req_col),
      .req_shape_mask(req_shape_mask), .req_shape_rows(req_shape_rows),
      .req_shape_cols(req_shape_cols), .req_piece_id(req_piece_id),
      .req_cell_value(req_cell_value),
      .rsp_fits(rsp_fits), .rsp_empty_cells(rsp_empty_cells),
      .rsp_shape_cells(rsp_shape_cells), .rsp_divisible(rsp_divisible),
      .rsp_full_res(rsp_full_res)
   );
endmodule

@@ rtl/gspe_datapath.sv @@
`timescale 1ns / 1ps
module gspe_datapath
   import gspe_pkg::*;
#(
   parameter int GRID_ROWS  = GRID_ROWS_DEF,
   parameter int GRID_COLS  = GRID_COLS_DEF,
   parameter int SHAPE_SIDE = SHAPE_SIDE_DEF,
   parameter int ID_BITS    = ID_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gspe_cmd_type                cmd,
   output gspe_sts_type                sts,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [SIZE_W-1:0]           csr_data,
   input  logic [1:0]                  req_op,
   input  logic [3:0]                  req_row,
   input  logic [3:0]                  req_col,
   input  logic [MASK_W-1:0]           req_shape_mask,
   input  logic [3:0]                  req_shape_rows,
   input  logic [3:0]                  req_shape_cols,
   input  logic [7:0]                  req_piece_id,
   input  logic signed [CELL_W-1:0]    req_cell_value,
   output logic                        rsp_fits,
   output logic [CNT_W-1:0]            rsp_empty_cells,
   output logic [SCNT_W-1:0]           rsp_shape_cells,
   output logic                        rsp_divisible,
   output logic                        rsp_full_res
);
   localparam int DEPTH = GRID_ROWS * GRID_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int SW    = 3;
   localparam int EW    = $clog2(DEPTH + 1) + 1;
   localparam int DW    = EW + 9;

   // grid storage with valid bits so reset reads as empty
   logic signed [CELL_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;

   logic [SIZE_W-1:0] rows_ff, cols_ff;
   logic [1:0] op_ff;
   logic [3:0] row_ff, col_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [3:0] srows_ff, scols_ff;
   logic [7:0] pid_ff;
   logic signed [CELL_W-1:0] cval_ff;
   logic [SW-1:0] sr_ff, sc_ff;
   logic [AW:0] sweep_ff;
   logic [RW-1:0] sw_r_ff;
   logic [CW-1:0] sw_c_ff;
   logic fits_ff;
   logic [EW-1:0] empty_ff;
   logic [SCNT_W-1:0] cells_ff;
   logic [EW-1:0] rem_ff;
   logic [3:0] mstep_ff;
   logic fits_o_ff, div_o_ff, full_o_ff;
   logic [CNT_W-1:0] empty_o_ff;
   logic [SCNT_W-1:0] cells_o_ff;
   logic signed [CELL_W-1:0] rd_val_ff;
   logic rd_vld_ff;
   logic chk_ff, swp_ff, swp_use_ff;
   logic [AW-1:0] swp_addr_ff;

   // effective sizes
   logic [6:0] nr, nc;
   assign nr = (32'(rows_ff) < GRID_ROWS) ? 7'(rows_ff) : 7'(GRID_ROWS);
   assign nc = (32'(cols_ff) < GRID_COLS) ? 7'(cols_ff) : 7'(GRID_COLS);
   logic [3:0] srows_c, scols_c;
   assign srows_c = (32'(req_shape_rows) < SHAPE_SIDE) ? req_shape_rows : 4'(SHAPE_SIDE);
   assign scols_c = (32'(req_shape_cols) < SHAPE_SIDE) ? req_shape_cols : 4'(SHAPE_SIDE);

   // shape cell walk position
   logic [6:0] gr, gc;
   logic mbit, in_grid, in_box;
   assign gr = 7'(row_ff) + 7'(sr_ff);
   assign gc = 7'(col_ff) + 7'(sc_ff);
   assign mbit = mask_ff[{sr_ff, sc_ff}];
   assign in_box = (4'(sr_ff) < srows_ff) && (4'(sc_ff) < scols_ff);
   assign in_grid = (gr < nr) && (gc < nc);
   logic [AW-1:0] sh_addr;
   assign sh_addr = AW'(32'(gr) * GRID_COLS + 32'(gc));

   logic bounds_ok;
   assign bounds_ok = (7'(row_ff) + 7'(srows_ff) <= nr) && (7'(col_ff) + 7'(scols_ff) <= nc);

   // sweep position
   logic [AW-1:0] sw_addr;
   logic sw_in_use;
   assign sw_addr = sweep_ff[AW-1:0];
   assign sw_in_use = (7'(sw_r_ff) < nr) && (7'(sw_c_ff) < nc);

   // single registered read port, data lands in the cycle after the address
   logic [AW-1:0] rd_addr;
   assign rd_addr = cmd.shape_step ? sh_addr : sw_addr;
   always_ff @(posedge clock) begin
      rd_val_ff <= mem[rd_addr];
      rd_vld_ff <= vld_ff[rd_addr];
   end

   logic signed [CELL_W-1:0] rd_cell;
   assign rd_cell = rd_vld_ff ? rd_val_ff : '0;

   // second stage of the shape check and of the sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
         swp_ff <= 1'b0;
      end else begin
         chk_ff <= cmd.shape_step && op_ff == OP_CHECK && in_box && mbit;
         swp_ff <= cmd.sweep_step;
      end
   end

   always_ff @(posedge clock) begin
      swp_use_ff <= sw_in_use;
      swp_addr_ff <= sw_addr;
   end

   logic rm_hit;
   assign rm_hit = swp_ff && op_ff == OP_REMOVE && rd_cell == $signed({1'b0, pid_ff});

   logic last_sc;
   assign last_sc = (32'(sc_ff) == SHAPE_SIDE - 1) || (4'(sc_ff) + 4'd1 >= scols_ff);
   assign sts.shape_last = last_sc &&
      ((32'(sr_ff) == SHAPE_SIDE - 1) || (4'(sr_ff) + 4'd1 >= srows_ff));
   assign sts.sweep_last = (32'(sweep_ff) == DEPTH - 1);
   assign sts.mod_last = (mstep_ff == 4'd0);
   assign sts.op = op_ff;

   logic [CELL_W-1:0] stamp_v;
   assign stamp_v = CELL_W'(pid_ff & 8'((1 << ID_BITS) - 1));

   // grid writes
   always_ff @(posedge clock) begin
      if (cmd.shape_step && op_ff == OP_STAMP && in_box && mbit && in_grid) begin
         mem[sh_addr] <= stamp_v;
      end else if (rm_hit) begin
         mem[swp_addr_ff] <= '0;
      end else if (cmd.write_cell && 7'(row_ff) < nr && 7'(col_ff) < nc) begin
         mem[AW'(32'(row_ff) * GRID_COLS + 32'(col_ff))] <= cval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.shape_step && op_ff == OP_STAMP && in_box && mbit && in_grid) begin
         vld_ff[sh_addr] <= 1'b1;
      end else if (cmd.write_cell && 7'(row_ff) < nr && 7'(col_ff) < nc) begin
         vld_ff[AW'(32'(row_ff) * GRID_COLS + 32'(col_ff))] <= 1'b1;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_W'(16);
         cols_ff <= SIZE_W'(16);
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_data;
            CSR_COLS: cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // request capture, walks and counters
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         row_ff <= req_row;
         col_ff <= req_col;
         mask_ff <= req_shape_mask;
         srows_ff <= srows_c;
         scols_ff <= scols_c;
         pid_ff <= req_piece_id;
         cval_ff <= req_cell_value;
         sr_ff <= '0;
         sc_ff <= '0;
         cells_ff <= '0;
         fits_ff <= 1'b1;
      end else begin
         if (cmd.shape_step) begin
            if (in_box && mbit) cells_ff <= cells_ff + 1'b1;
            if (last_sc) begin
               sc_ff <= '0;
               sr_ff <= sr_ff + 1'b1;
            end else begin
               sc_ff <= sc_ff + 1'b1;
            end
         end
         // drop the fit on any covered cell that is not empty
         if (chk_ff && rd_cell != 0) fits_ff <= 1'b0;
      end
      if (cmd.sweep_clr) begin
         sweep_ff <= '0;
         sw_r_ff <= '0;
         sw_c_ff <= '0;
         empty_ff <= '0;
      end else begin
         if (cmd.sweep_step) begin
            sweep_ff <= sweep_ff + 1'b1;
            if (32'(sw_c_ff) == GRID_COLS - 1) begin
               sw_c_ff <= '0;
               sw_r_ff <= sw_r_ff + 1'b1;
            end else begin
               sw_c_ff <= sw_c_ff + 1'b1;
            end
         end
         // cells being cleared this step count as empty
         if (swp_ff && swp_use_ff && (rd_cell == 0 || rm_hit))
            empty_ff <= empty_ff + 1'b1;
      end
   end

   // remainder by restoring shift-subtract, one bit a step
   logic [DW-1:0] dsh;
   assign dsh = DW'(cells_ff) << mstep_ff;
   logic [EW-1:0] trial;
   always_comb begin
      trial = ({9'd0, rem_ff} >= dsh) ? EW'({9'd0, rem_ff} - dsh) : rem_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         rem_ff <= empty_ff;
         mstep_ff <= 4'd8;
      end else if (cmd.mod_step) begin
         rem_ff <= trial;
         mstep_ff <= mstep_ff - 1'b1;
      end
   end

   // result beat
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         fits_o_ff <= (op_ff == OP_CHECK) ? (bounds_ok && fits_ff) : 1'b0;
         empty_o_ff <= CNT_W'(empty_ff);
         cells_o_ff <= cells_ff;
         div_o_ff <= (cells_ff != 0) && (trial == '0);
         full_o_ff <= (empty_ff == '0);
      end
   end

   assign rsp_fits = fits_o_ff;
   assign rsp_empty_cells = empty_o_ff;
   assign rsp_shape_cells = cells_o_ff;
   assign rsp_divisible = div_o_ff;
   assign rsp_full_res = full_o_ff;
endmodule

@@ rtl/gspe_ctrl.sv @@
`timescale 1ns / 1ps
module gspe_ctrl
   import gspe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output gspe_cmd_type cmd,
   input  gspe_sts_type sts
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SHAPE = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_MODLD = 3'd5;
   localparam logic [2:0] ST_MOD   = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            cmd.shape_step = 1'b1;
            if (sts.shape_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_cell = (sts.op == OP_WRITE);
            cmd.sweep_clr = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) state_in = ST_DRAIN;
         end
         // let the last grid read land in the count
         ST_DRAIN: state_in = ST_MODLD;
         ST_MODLD: begin
            cmd.mod_start = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (sts.mod_last) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
endmodule

@@ bench/grid_checker.sv @@
`timescale 1ns / 1ps
module grid_checker
   import gspe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [1:0]               req_op,
   input  logic [3:0]               req_row,
   input  logic [3:0]               req_col,
   input  logic [MASK_W-1:0]        req_shape_mask,
   input  logic [3:0]               req_shape_rows,
   input  logic [3:0]               req_shape_cols,
   input  logic [7:0]               req_piece_id,
   input  logic signed [CELL_W-1:0] req_cell_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_fits,
   input  logic [CNT_W-1:0]         rsp_empty_cells,
   input  logic [SCNT_W-1:0]        rsp_shape_cells,
   input  logic                     rsp_divisible,
   input  logic                     rsp_full_res,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SIZE_W-1:0]        csr_data,
   output int                       fail_count,
   output int                       pending,
   output int                       beats_checked
);

   typedef struct packed {
      logic              fits;
      logic [CNT_W-1:0]  empty;
      logic [SCNT_W-1:0] cells;
      logic              divisible;
      logic              full;
   } placement_result_type;

   logic signed [CELL_W-1:0] occupancy [GRID_ROWS_DEF*GRID_COLS_DEF];
   logic [SIZE_W-1:0]        rows_reg;
   logic [SIZE_W-1:0]        cols_reg;
   placement_result_type     awaited_q [$];

   function automatic int clamp_side(logic [3:0] v);
      return (v < SHAPE_SIDE_DEF) ? int'(v) : SHAPE_SIDE_DEF;
   endfunction

   // Apply one request beat to the grid copy and work out its result
   function automatic placement_result_type place_and_count(
      logic [1:0] op, int row, int col, logic [MASK_W-1:0] mask,
      int srows, int scols, logic [7:0] pid, logic signed [CELL_W-1:0] cval);
      placement_result_type res;
      int nr;
      int nc;
      int empty;
      int cells;
      nr = (rows_reg < GRID_ROWS_DEF) ? int'(rows_reg) : GRID_ROWS_DEF;
      nc = (cols_reg < GRID_COLS_DEF) ? int'(cols_reg) : GRID_COLS_DEF;
      res = '0;
      empty = 0;
      cells = 0;
      case (op)
         OP_CHECK: begin
            if (row + srows <= nr && col + scols <= nc) begin
               res.fits = 1'b1;
               for (int r = 0; r < srows; r++)
                  for (int c = 0; c < scols; c++)
                     if (mask[r*8+c] && occupancy[(row+r)*GRID_COLS_DEF+col+c] != 0)
                        res.fits = 1'b0;
            end
         end
         OP_STAMP: begin
            for (int r = 0; r < srows; r++)
               for (int c = 0; c < scols; c++)
                  if (mask[r*8+c] && row + r < nr && col + c < nc)
                     occupancy[(row+r)*GRID_COLS_DEF+col+c] = {1'b0, pid};
         end
         OP_REMOVE: begin
            for (int i = 0; i < GRID_ROWS_DEF*GRID_COLS_DEF; i++)
               if (occupancy[i] == $signed({1'b0, pid}))
                  occupancy[i] = '0;
         end
         default: begin
            if (row < nr && col < nc)
               occupancy[row*GRID_COLS_DEF+col] = cval;
         end
      endcase
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (occupancy[r*GRID_COLS_DEF+c] == 0)
               empty++;
      for (int r = 0; r < srows; r++)
         for (int c = 0; c < scols; c++)
            if (mask[r*8+c])
               cells++;
      res.empty     = empty[CNT_W-1:0];
      res.cells     = cells[SCNT_W-1:0];
      res.divisible = (cells != 0) && (empty % cells == 0);
      res.full      = (empty == 0);
      return res;
   endfunction

   // Track registers and requests, compare each result beat
   always @(posedge clock) begin
      placement_result_type want;
      placement_result_type got;
      if (reset) begin
         foreach (occupancy[i]) occupancy[i] <= '0;
         rows_reg <= 5'd16;
         cols_reg <= 5'd16;
         awaited_q.delete();
         fail_count <= 0;
         beats_checked <= 0;
         pending <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_ROWS) rows_reg <= csr_data;
            else if (csr_index == CSR_COLS) cols_reg <= csr_data;
         end
         if (start && !busy)
            awaited_q.push_back(place_and_count(req_op, int'(req_row), int'(req_col),
               req_shape_mask, clamp_side(req_shape_rows), clamp_side(req_shape_cols),
               req_piece_id, req_cell_value));
         if (rsp_valid) begin
            got = '{rsp_fits, rsp_empty_cells, rsp_shape_cells, rsp_divisible,
                    rsp_full_res};
            beats_checked <= beats_checked + 1;
            if (awaited_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result beat with nothing awaited", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch fits %0b/%0b empty %0d/%0d cells %0d/%0d div %0b/%0b full %0b/%0b (exp/act)",
                        $realtime, want.fits, got.fits, want.empty, got.empty,
                        want.cells, got.cells, want.divisible, got.divisible,
                        want.full, got.full);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= awaited_q.size();
      end
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import gspe_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_op = OP_CHECK;
   logic [3:0]               req_row = '0;
   logic [3:0]               req_col = '0;
   logic [MASK_W-1:0]        req_shape_mask = '0;
   logic [3:0]               req_shape_rows = 4'd1;
   logic [3:0]               req_shape_cols = 4'd1;
   logic [7:0]               req_piece_id = 8'd1;
   logic signed [CELL_W-1:0] req_cell_value = '0;
   logic                     rsp_valid;
   logic                     rsp_fits;
   logic [CNT_W-1:0]         rsp_empty_cells;
   logic [SCNT_W-1:0]        rsp_shape_cells;
   logic                     rsp_divisible;
   logic                     rsp_full_res;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = CSR_ROWS;
   logic [SIZE_W-1:0]        csr_data = '0;
   int                       fail_count;
   int                       pending;
   int                       beats_checked;
   int                       cycle_count = 0;
   int                       items_sent = 0;
   int                       idle_pct = 0;

   always #5 clock = ~clock;

   grid_shape_placement_engine dut (.*);

   grid_checker chk (.*);

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Drive one request beat and hold it until taken
   task automatic send_request(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                               logic [63:0] mask, logic [3:0] sr, logic [3:0] sc,
                               logic [7:0] pid, logic [8:0] cval);
      while ($urandom_range(99) < idle_pct) @(negedge clock);
      while (busy) @(negedge clock);
      start = 1'b1;
      req_op = op;
      req_row = row;
      req_col = col;
      req_shape_mask = mask;
      req_shape_rows = sr;
      req_shape_cols = sc;
      req_piece_id = pid;
      req_cell_value = cval;
      @(negedge clock);
      start = 1'b0;
      items_sent++;
   endtask

   task automatic drain();
      while (pending != 0 || busy) @(negedge clock);
   endtask

   task automatic set_sheet(logic [4:0] rows, logic [4:0] cols);
      drain();
      csr_write = 1'b1;
      csr_index = CSR_ROWS;
      csr_data = rows;
      @(negedge clock);
      csr_index = CSR_COLS;
      csr_data = cols;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Random beat: mostly small shapes and a small pool of pieces so that
   // stamps, checks and removes keep meeting each other
   task automatic random_request();
      logic [1:0]  op;
      logic [3:0]  sr;
      logic [3:0]  sc;
      logic [63:0] mask;
      logic [7:0]  pid;
      int          pick;
      pick = $urandom_range(99);
      op = (pick < 30) ? OP_CHECK : (pick < 60) ? OP_STAMP :
           (pick < 80) ? OP_REMOVE : OP_WRITE;
      sr = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(4, 1));
      sc = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(4, 1));
      pick = $urandom_range(9);
      if (pick == 0) mask = '0;
      else if (pick < 3) mask = {$urandom, $urandom};
      else begin
         mask = '0;
         for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
               if (r < sr && c < sc && $urandom_range(3) != 0) mask[r*8+c] = 1'b1;
      end
      pid = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(5, 1));
      send_request(op, 4'($urandom), 4'($urandom), mask, sr, sc, pid, 9'($urandom));
   endtask

   initial begin
      int phase_pct [4];
      phase_pct = '{0, 52, 12, 0};
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed: empty sheet, full shape, clamps, holes, odd values
      send_request(OP_CHECK,  4'd0, 4'd0, '1, 4'd8, 4'd8, 8'd1, 9'd0);
      send_request(OP_STAMP,  4'd0, 4'd0, '1, 4'd8, 4'd8, 8'd255, 9'd0);
      send_request(OP_CHECK,  4'd0, 4'd0, 64'h1, 4'd1, 4'd1, 8'd1, 9'd0);
      send_request(OP_CHECK,  4'd8, 4'd8, '1, 4'd15, 4'd15, 8'd1, 9'd0);
      send_request(OP_CHECK,  4'd9, 4'd0, 64'h1, 4'd8, 4'd1, 8'd1, 9'd0);
      send_request(OP_STAMP,  4'd12, 4'd12, '1, 4'd8, 4'd8, 8'd7, 9'd0);
      send_request(OP_STAMP,  4'd0, 4'd0, 64'h3, 4'd1, 4'd2, 8'd0, 9'd0);
      send_request(OP_REMOVE, 4'd0, 4'd0, '0, 4'd0, 4'd0, 8'd0, 9'd0);
      send_request(OP_REMOVE, 4'd0, 4'd0, '0, 4'd0, 4'd0, 8'd255, 9'd0);
      send_request(OP_WRITE,  4'd15, 4'd15, 64'h8000000000000000, 4'd8, 4'd8, 8'd1, 9'h1FF);
      send_request(OP_WRITE,  4'd3, 4'd4, 64'h5, 4'd1, 4'd3, 8'd1, 9'h100);
      send_request(OP_WRITE,  4'd3, 4'd5, 64'h5, 4'd1, 4'd3, 8'd1, 9'h0FF);
      send_request(OP_CHECK,  4'd3, 4'd4, 64'h1, 4'd1, 4'd1, 8'd1, 9'd0);
      send_request(OP_REMOVE, 4'd0, 4'd0, '1, 4'd8, 4'd8, 8'd7, 9'd0);
      send_request(OP_WRITE,  4'd3, 4'd4, 64'h1, 4'd1, 4'd1, 8'd1, 9'd0);
      // fill the sheet to reach the full flag
      send_request(OP_STAMP,  4'd0, 4'd0, '1, 4'd8, 4'd8, 8'd9, 9'd0);
      send_request(OP_STAMP,  4'd0, 4'd8, '1, 4'd8, 4'd8, 8'd9, 9'd0);
      send_request(OP_STAMP,  4'd8, 4'd0, '1, 4'd8, 4'd8, 8'd9, 9'd0);
      send_request(OP_STAMP,  4'd8, 4'd8, '1, 4'd8, 4'd8, 8'd9, 9'd0);
      send_request(OP_REMOVE, 4'd0, 4'd0, 64'h3, 4'd2, 4'd2, 8'd9, 9'd0);

      // zero-size sheet, then oversize registers
      set_sheet(5'd0, 5'd0);
      send_request(OP_CHECK, 4'd0, 4'd0, 64'h1, 4'd1, 4'd1, 8'd1, 9'd0);
      send_request(OP_WRITE, 4'd0, 4'd0, 64'h1, 4'd1, 4'd1, 8'd1, 9'd5);
      set_sheet(5'd31, 5'd31);
      send_request(OP_CHECK, 4'd0, 4'd0, 64'h1, 4'd1, 4'd1, 8'd1, 9'd0);

      // Random phases over several sheet sizes and idling levels
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 6)
            0: set_sheet(5'd16, 5'd16);
            1: set_sheet(5'd1, 5'd1);
            2: set_sheet(5'd31, 5'd5);
            3: set_sheet(5'd0, 5'd16);
            4: set_sheet(5'd6, 5'd11);
            default: set_sheet(5'($urandom_range(17, 1)), 5'($urandom_range(17, 1)));
         endcase
         idle_pct = phase_pct[phase % 4];
         repeat (48) random_request();
         if (phase == 5) drain();
      end

      drain();
      repeat (400) @(negedge clock);
      $display("%0d request beats sent, %0d result beats checked over 14 sheet sizes",
               items_sent, beats_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
